[rtl/core/casp_pkg.sv]
package casp_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    // Column and row positions; sizes need one more bit to hold the maximum.
    localparam int POS_W  = $clog2(MAX_WIDTH);
    localparam int DIM_W  = 9;
    localparam int THR_W  = 4;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [DIM_W-1:0] MIN_DIM    = DIM_W'(3);
    localparam logic [DIM_W-1:0] MAX_W_DIM  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_DIM  = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'(256);
    localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(256);
    localparam logic [THR_W-1:0] RST_THRESH = THR_W'(5);

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_THRESH = 2'd2
    } reg_idx_t;

    // Results an item still owes: interior-lagged tile, right border of the
    // row above, bottom border tile, bottom right corner.
    typedef struct packed {
        logic corner;
        logic bottom;
        logic right;
        logic lagged;
    } pend_t;

    function automatic logic [1:0] ones3(input logic [2:0] v);
        ones3 = {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
    endfunction

endpackage

[rtl/core/ca_smoothing_pass_3x3.sv]
// The first result of a tile passes from its input transfer through the compute stage
// registers and then into the output register.
// Throughput: one tile per cycle while the output is not stalled and the tile owes at most
// one result; a tile owing more (two at a row end below the top row or in the last row past
// its first column, four for the last tile) holds the compute stage and stalls the input
// until its last result enters the single output register, one result per cycle when free.
// Reset: counters, window and handshake state clear and the registers return to
// 256 x 256 with threshold 5; the row store RAM is not cleared.
module ca_smoothing_pass_3x3
    import casp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic              land_in,

    output logic              out_valid,
    input  logic              out_stall,
    output logic              land_out,
    output logic [POS_W-1:0]  out_column,
    output logic [POS_W-1:0]  out_row,
    output logic              last_of_run,
    output logic              last_of_frame
);

    // Configuration registers
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [THR_W-1:0] thresh_reg;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            thresh_reg <= RST_THRESH;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                REG_THRESH: thresh_reg <= pwdata[THR_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_WIDTH:  prdata = DATA_W'(width_reg);
            REG_HEIGHT: prdata = DATA_W'(height_reg);
            REG_THRESH: prdata = DATA_W'(thresh_reg);
            default:    prdata = '0;
        endcase
    end

    // Sizes clamped to the supported range
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;

    always_comb
    begin
        priority if (width_reg < MIN_DIM)   w_eff = MIN_DIM;
        else if (width_reg > MAX_W_DIM)     w_eff = MAX_W_DIM;
        else                                w_eff = width_reg;

        priority if (height_reg < MIN_DIM)  h_eff = MIN_DIM;
        else if (height_reg > MAX_H_DIM)    h_eff = MAX_H_DIM;
        else                                h_eff = height_reg;
    end

    // Input position and per-item decode at the input transfer
    logic [POS_W-1:0] col_reg;
    logic [POS_W-1:0] row_reg;
    logic [POS_W-1:0] col_next;
    logic [POS_W-1:0] row_next;
    logic             in_xfer;
    logic             last_col;
    logic             last_row;
    logic             interior;
    pend_t            pend_init;

    assign in_xfer  = in_valid && !in_stall;
    assign last_col = {1'b0, col_reg} >= (w_eff - DIM_W'(1));
    assign last_row = {1'b0, row_reg} >= (h_eff - DIM_W'(1));
    assign interior = (row_reg >= POS_W'(2)) && ({1'b0, row_reg} <= h_eff - DIM_W'(1))
                   && (col_reg >= POS_W'(2)) && ({1'b0, col_reg} <= w_eff - DIM_W'(1));

    always_comb
    begin
        pend_init.lagged = (row_reg != '0) && (col_reg != '0);
        pend_init.right  = (row_reg != '0) && last_col;
        pend_init.bottom = last_row && (col_reg != '0);
        pend_init.corner = last_row && last_col;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + POS_W'(1);
        end
        else
        begin
            col_next = col_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_xfer)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Row store: bit 0 holds the row two above, bit 1 the row just above.
    // The entry read at a transfer is written back when that tile leaves the
    // compute stage. The next access to the same column is at least three
    // tiles later, so read and write never meet on one entry.
    logic [1:0]       row_mem [MAX_WIDTH];
    logic [1:0]       rd_reg;
    logic             mem_wr;

    // Compute stage
    logic             s1_valid_reg;
    pend_t            s1_pend_reg;
    logic             s1_land_reg;
    logic             s1_interior_reg;
    logic [POS_W-1:0] s1_col_reg;
    logic [POS_W-1:0] s1_row_reg;

    logic [5:0]       window_reg;
    logic [5:0]       window_next;
    logic [2:0]       cur;
    logic [3:0]       land_cnt;
    logic             land_calc;

    pend_t            pick;
    pend_t            pend_left;
    logic             out_free;
    logic             out_load;
    logic             s1_done;

    // Output register
    logic             out_valid_reg;
    logic             land_out_reg;
    logic [POS_W-1:0] out_column_reg;
    logic [POS_W-1:0] out_row_reg;
    logic             last_of_run_reg;
    logic             last_of_frame_reg;

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            rd_reg <= row_mem[col_reg];
        end
        if (mem_wr)
        begin
            row_mem[s1_col_reg] <= {s1_land_reg, rd_reg[1]};
        end
    end

    assign cur       = {s1_land_reg, rd_reg};
    assign land_cnt  = {2'b00, ones3(window_reg[2:0])} + {2'b00, ones3(cur)}
                     + {3'b000, window_reg[3]} + {3'b000, window_reg[5]};
    assign land_calc = s1_interior_reg ? (land_cnt >= thresh_reg) : 1'b1;
    assign window_next = {cur, window_reg[5:3]};

    always_comb
    begin
        pick = '0;
        priority if (s1_pend_reg.lagged) pick.lagged = 1'b1;
        else if (s1_pend_reg.right)      pick.right  = 1'b1;
        else if (s1_pend_reg.bottom)     pick.bottom = 1'b1;
        else if (s1_pend_reg.corner)     pick.corner = 1'b1;
        else                             pick = '0;
    end

    assign pend_left = s1_pend_reg & ~pick;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = s1_valid_reg && (pick != '0) && out_free;
    // The tile finishes when its last result is loaded into the output register, or at once if it owes none.
    assign s1_done   = s1_valid_reg && ((s1_pend_reg == '0) || (out_load && pend_left == '0));
    assign mem_wr    = s1_done;
    assign in_stall  = s1_valid_reg && !s1_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_pend_reg  <= '0;
            window_reg   <= '0;
        end
        else
        begin
            if (s1_done)
            begin
                window_reg <= window_next;
            end
            if (in_xfer)
            begin
                s1_valid_reg <= 1'b1;
                s1_pend_reg  <= pend_init;
            end
            else if (s1_done)
            begin
                s1_valid_reg <= 1'b0;
                s1_pend_reg  <= '0;
            end
            else if (out_load)
            begin
                s1_pend_reg <= pend_left;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_land_reg     <= land_in;
            s1_interior_reg <= interior;
            s1_col_reg      <= col_reg;
            s1_row_reg      <= row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= out_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            land_out_reg      <= pick.lagged ? land_calc : 1'b1;
            out_column_reg    <= (pick.lagged || pick.bottom) ? s1_col_reg - POS_W'(1)
                                                              : s1_col_reg;
            out_row_reg       <= (pick.lagged || pick.right) ? s1_row_reg - POS_W'(1)
                                                             : s1_row_reg;
            last_of_run_reg   <= (pend_left == '0);
            last_of_frame_reg <= pick.corner;
        end
    end

    assign out_valid     = out_valid_reg;
    assign land_out      = land_out_reg;
    assign out_column    = out_column_reg;
    assign out_row       = out_row_reg;
    assign last_of_run   = last_of_run_reg;
    assign last_of_frame = last_of_frame_reg;

    // The row store must never be read and written at the same entry in one cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && mem_wr) |-> (col_reg != s1_col_reg))
        else $error("row store read and write collide");

    // The bottom right tile always closes the burst of its input tile.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_of_frame_reg) |-> last_of_run_reg)
        else $error("frame end not at end of burst");

    // A corner tile also owes every other result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && pend_init.corner) |=>
            (s1_pend_reg.lagged && s1_pend_reg.right && s1_pend_reg.bottom))
        else $error("corner tile with incomplete result set");

endmodule

[dv/casp_pass_checker.sv]
module casp_pass_checker
    import casp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,

    input  logic              in_valid,
    input  logic              in_stall,
    input  logic              land_in,

    input  logic              out_valid,
    input  logic              out_stall,
    input  logic              land_out,
    input  logic [POS_W-1:0]  out_column,
    input  logic [POS_W-1:0]  out_row,
    input  logic              last_of_run,
    input  logic              last_of_frame,

    output int                mismatches,
    output int                owed_count
);

    typedef struct packed {
        logic             land;
        logic [POS_W-1:0] column;
        logic [POS_W-1:0] row;
        logic             run_end;
        logic             frame_end;
    } tile_t;

    tile_t owed_tiles[$];
    tile_t oldest;

    logic [DIM_W-1:0] map_width;
    logic [DIM_W-1:0] map_height;
    logic [THR_W-1:0] land_threshold;

    // Two rows of history and the two columns left of the incoming tile.
    logic             older_rows [MAX_WIDTH];
    logic             newer_rows [MAX_WIDTH];
    logic [5:0]       window;
    logic [POS_W-1:0] col_pos;
    logic [POS_W-1:0] row_pos;

    function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int top);
        if (v < 3)
            return 3;
        if (v > top)
            return top;
        return int'(v);
    endfunction

    function automatic tile_t make_tile(input logic land, input int c, input int r,
                                        input logic frame_end);
        tile_t t;
        t.land      = land;
        t.column    = c[POS_W-1:0];
        t.row       = r[POS_W-1:0];
        t.run_end   = 1'b0;
        t.frame_end = frame_end;
        return t;
    endfunction

    task automatic smooth_tile(input logic tile);
        int         w;
        int         h;
        int         i;
        int         j;
        int         count;
        int         n;
        logic [2:0] cur;
        logic       last_col;
        logic       last_row;
        logic       land;
        tile_t      burst [4];

        w = clamp_dim(map_width, MAX_WIDTH);
        h = clamp_dim(map_height, MAX_HEIGHT);
        i = int'(row_pos);
        j = int'(col_pos);
        last_col = (j >= w - 1);
        last_row = (i >= h - 1);
        cur = {tile, newer_rows[j], older_rows[j]};
        n = 0;

        // The lagged tile sits one row up and one column left; its center is
        // the middle of the window and does not count toward its neighbors.
        if (i >= 1 && j >= 1) begin
            land = 1'b1;
            if (i - 1 >= 1 && i - 1 <= h - 2 && j - 1 >= 1 && j - 1 <= w - 2) begin
                count = $countones(window[2:0]) + $countones(cur)
                      + int'(window[3]) + int'(window[5]);
                land = (count >= int'(land_threshold));
            end
            burst[n] = make_tile(land, j - 1, i - 1, 1'b0);
            n++;
        end
        if (i >= 1 && last_col) begin
            burst[n] = make_tile(1'b1, j, i - 1, 1'b0);
            n++;
        end
        if (last_row && j >= 1) begin
            burst[n] = make_tile(1'b1, j - 1, i, 1'b0);
            n++;
        end
        if (last_row && last_col) begin
            burst[n] = make_tile(1'b1, j, i, 1'b1);
            n++;
        end
        if (n > 0)
            burst[n-1].run_end = 1'b1;
        for (int k = 0; k < n; k++)
            owed_tiles = {owed_tiles, burst[k]};

        older_rows[j] = newer_rows[j];
        newer_rows[j] = tile;
        window = {cur, window[5:3]};
        if (last_col) begin
            col_pos = '0;
            row_pos = last_row ? '0 : POS_W'(i + 1);
        end
        else begin
            col_pos = POS_W'(j + 1);
        end
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            map_width      = RST_WIDTH;
            map_height     = RST_HEIGHT;
            land_threshold = RST_THRESH;
            foreach (older_rows[k]) begin
                older_rows[k] = 1'b0;
                newer_rows[k] = 1'b0;
            end
            window  = '0;
            col_pos = '0;
            row_pos = '0;
            owed_tiles.delete();
            mismatches = 0;
            owed_count <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[ADDR_W-1:2]))
                    REG_WIDTH:  map_width      = pwdata[DIM_W-1:0];
                    REG_HEIGHT: map_height     = pwdata[DIM_W-1:0];
                    REG_THRESH: land_threshold = pwdata[THR_W-1:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                smooth_tile(land_in);

            if (out_valid && !out_stall) begin
                if (owed_tiles.size() == 0) begin
                    $error("result transfer with nothing owed: column %0d, row %0d",
                           out_column, out_row);
                    mismatches++;
                end
                else begin
                    oldest = owed_tiles.pop_front();
                    compare_field("land_out", oldest.land, land_out);
                    compare_field("out_column", oldest.column, out_column);
                    compare_field("out_row", oldest.row, out_row);
                    compare_field("last_of_run", oldest.run_end, last_of_run);
                    compare_field("last_of_frame", oldest.frame_end, last_of_frame);
                end
            end

            owed_count <= owed_tiles.size();
        end
    end

endmodule

[dv/tb_ca_smoothing_pass_3x3.sv]
module tb_ca_smoothing_pass_3x3;
    import casp_pkg::*;

    localparam int RANDOM_TILES = 380;
    localparam int TAIL_TILES   = 80;
    localparam int LONG_HOLD    = 60;
    localparam int QUIET_LIMIT  = 2000;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    logic              land_in;
    logic              out_valid;
    logic              out_stall;
    logic              land_out;
    logic [POS_W-1:0]  out_column;
    logic [POS_W-1:0]  out_row;
    logic              last_of_run;
    logic              last_of_frame;
    int                mismatches;
    int                owed_count;

    bit                idle_in;
    bit                quiet_tail;
    bit                long_hold_req;
    int                quiet_cycles;

    ca_smoothing_pass_3x3 DUT (.*);

    casp_pass_checker u_checker (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Ends the run if nothing moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver side: random stall bursts, calm stretches, and one long hold.
    initial
    begin
        bit calm;
        bit held;
        calm = 1'b0;
        held = 1'b0;
        out_stall = 1'b0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (long_hold_req && !held) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
                held = 1'b1;
            end
            else if (!quiet_tail && !calm && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_stall <= 1'b0;
            end
            if ($urandom_range(0, 99) == 0)
                calm = !calm;
        end
    end

    // Leaves psel and penable high; the caller drops them after its last write.
    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    // Waits until every owed result has been transferred and the block is quiet.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (owed_count != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_map(input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] h,
                           input logic [DATA_W-1:0] thr);
        drain();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_THRESH, thr);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Valid stays high from one transfer to the next unless a gap is drawn.
    task automatic send_tile(input logic tile);
        if (!quiet_tail && idle_in && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        land_in  <= tile;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_frame(input int w, input int h, input int density,
                              input bit pause_midway);
        for (int k = 0; k < w * h; k++) begin
            if (pause_midway && k == (w * h) / 2)
                drain();
            send_tile($urandom_range(0, 99) < density);
        end
    endtask

    // Phase 0 holds the receiver off for a long stretch; phase 1 pauses the
    // sender midway until every owed result is out.
    task automatic run_phase(input int phase, inout int tiles);
        int                w;
        int                h;
        int                density;
        logic [DATA_W-1:0] w_reg;
        logic [DATA_W-1:0] h_reg;
        logic [DATA_W-1:0] thr;

        w = $urandom_range(3, ($urandom_range(0, 3) == 0) ? 24 : 10);
        h = $urandom_range(3, 8);
        if (phase == 0) begin
            w = 10;
            h = 6;
        end

        // Sizes at the lower edge are sometimes written out of range.
        w_reg = w;
        h_reg = h;
        if (w == 3 && $urandom_range(0, 1) == 1)
            w_reg = $urandom_range(0, 2);
        if (h == 3 && $urandom_range(0, 1) == 1)
            h_reg = $urandom_range(0, 2);
        thr = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(3, 6);
        set_map(w_reg, h_reg, thr);

        if (phase == 0) begin
            idle_in = 1'b0;
            long_hold_req = 1'b1;
        end

        repeat ($urandom_range(1, 2)) begin
            if (phase != 0)
                idle_in = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0)
                density = ($urandom_range(0, 1) == 1) ? 100 : 0;
            else
                density = $urandom_range(15, 85);
            send_frame(w, h, density, phase == 1);
            tiles += w * h;
        end
    endtask

    initial
    begin
        int tiles;
        int phase;

        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        land_in   = 1'b0;
        idle_in   = 1'b1;
        quiet_tail    = 1'b0;
        long_hold_req = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Undersized map with a zero threshold: every interior tile is land.
        set_map(0, 1, 0);
        send_frame(3, 3, 0, 1'b0);
        // Threshold above eight: interior tiles can never become land.
        set_map(3, 3, 15);
        send_frame(3, 3, 100, 1'b0);
        // All eight neighbors land just meets a threshold of eight.
        set_map(2, 3, 8);
        send_frame(3, 3, 100, 1'b0);

        tiles = 0;
        phase = 0;
        while (tiles < RANDOM_TILES - TAIL_TILES) begin
            run_phase(phase, tiles);
            phase++;
        end
        quiet_tail = 1'b1;
        do begin
            run_phase(phase, tiles);
            phase++;
        end while (tiles < RANDOM_TILES);

        drain();
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/casp_pkg.sv
rtl/core/ca_smoothing_pass_3x3.sv
dv/casp_pass_checker.sv
dv/tb_ca_smoothing_pass_3x3.sv
